/* sv/tpep_pkg.sv */
`default_nettype none
package tpep_pkg;

	// Field widths fixed by the interface
	localparam int HASH_W    = 32;
	localparam int BACKLOG_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;
	localparam int MODE_W    = 2;

	// Scheduling modes; the unused code falls back to per-flow
	localparam logic [MODE_W-1:0] MODE_FLOW   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PACKET = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ECMP   = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PICK_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_WATER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOAD_BIAS  = 2'd2;

	// Register reset values
	localparam logic [MODE_W-1:0]    PICK_MODE_RESET  = MODE_FLOW;
	localparam logic [BACKLOG_W-1:0] HIGH_WATER_RESET = 16'd64;
	localparam logic [BACKLOG_W-1:0] LOAD_BIAS_RESET  = 16'd16;

	// Decision for one item and the state updates it implies
	typedef struct packed {
		logic chosen_port;
		logic port_valid;
		logic spilled;
		logic set_spill;  // commit the flow bucket
		logic rr_toggle;  // flip the alternation phase
	} pick_t;

endpackage
`default_nettype wire

/* sv/two_port_egress_picker.sv */
// An accepted item is registered in stage 1 and moves into the result register
// (stage 2) once that register frees. Throughput: one item per cycle while the
// output is not stalled and the spill map is not being cleared, a single
// combinational pass between the input and output registers. Reset: arst_n clears
// valids, the alternation phase and the configuration registers (mode 0, high
// water 64, bias 16); the input then stalls while a pass clears the flow-bucket spill map.
`default_nettype none
module two_port_egress_picker #(
	parameter int FLOW_BUCKETS = 256,
	parameter int BACKLOG_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,

	// Configuration write port
	input  wire logic                              cfg_wr_en,
	input  wire logic [tpep_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [tpep_pkg::CFG_DAT_W-1:0]    cfg_data,

	// Input channel
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [tpep_pkg::HASH_W-1:0]       flow_hash,
	input  wire logic                              port0_present,
	input  wire logic                              port1_present,
	input  wire logic [tpep_pkg::BACKLOG_W-1:0]    backlog0,
	input  wire logic [tpep_pkg::BACKLOG_W-1:0]    backlog1,
	input  wire logic                              pref_known,
	input  wire logic                              pref_port,

	// Output channel
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   chosen_port,
	output logic                                   port_valid,
	output logic                                   spilled
);

	// Bucket index width and mask; a non-power-of-two count still masks
	// with FLOW_BUCKETS-1, which never leaves the map.
	localparam int IDX_W = (FLOW_BUCKETS > 1) ? $clog2(FLOW_BUCKETS) : 1;
	localparam logic [IDX_W-1:0] IDX_MASK    = IDX_W'(FLOW_BUCKETS - 1);
	localparam logic [IDX_W-1:0] LAST_BUCKET = IDX_W'(FLOW_BUCKETS - 1);

	// Backlog saturation limit inside the fixed 16-bit field
	localparam logic [tpep_pkg::BACKLOG_W-1:0] BL_MAX =
		(BACKLOG_BITS >= tpep_pkg::BACKLOG_W) ? {tpep_pkg::BACKLOG_W{1'b1}} :
		tpep_pkg::BACKLOG_W'((64'd1 << BACKLOG_BITS) - 64'd1);

	// Configuration registers
	logic [tpep_pkg::MODE_W-1:0]    pick_mode_q;
	logic [tpep_pkg::BACKLOG_W-1:0] high_water_q;
	logic [tpep_pkg::BACKLOG_W-1:0] load_bias_q;

	// Decision state: one spill bit per flow bucket, and the alternation phase
	logic                    spill_mem [0:FLOW_BUCKETS-1];
	logic                    rr_phase_q;

	// Clearing pass over the spill map after reset
	logic                    clearing_q;
	logic [IDX_W-1:0]        clr_idx_q;

	// Stage 1: registered input item, backlogs already saturated
	logic                           valid_s1;
	logic [tpep_pkg::HASH_W-1:0]    flow_hash_s1;
	logic                           port0_present_s1;
	logic                           port1_present_s1;
	logic [tpep_pkg::BACKLOG_W-1:0] backlog0_s1;
	logic [tpep_pkg::BACKLOG_W-1:0] backlog1_s1;
	logic                           pref_known_s1;
	logic                           pref_port_s1;
	logic                           bucket_hit_s1;

	// Stage 2: result register facing the output channel
	logic valid_s2;
	logic chosen_port_s2;
	logic port_valid_s2;
	logic spilled_s2;

	logic            in_accept;
	logic            adv_s1;
	logic            s2_free;
	logic [IDX_W-1:0] idx_s1;
	logic [IDX_W-1:0] in_idx;
	logic            spill_wr;
	logic            fwd_hit;
	tpep_pkg::pick_t pick_s1;
	logic [tpep_pkg::BACKLOG_W-1:0] sat0;
	logic [tpep_pkg::BACKLOG_W-1:0] sat1;

	// Handshake: the result register frees when it is empty or being taken;
	// stage 1 moves into it whenever it frees, so stall while the spill map is
	// being cleared, or while both stages hold an item and the output is stalled.
	assign s2_free   = !valid_s2 || !out_stall;
	assign adv_s1    = valid_s1 && s2_free;
	assign in_stall  = clearing_q || (valid_s1 && !s2_free);
	assign in_accept = in_valid && !in_stall;

	// Clamp backlogs to the configured counter width on the way in
	assign sat0 = (backlog0 > BL_MAX) ? BL_MAX : backlog0;
	assign sat1 = (backlog1 > BL_MAX) ? BL_MAX : backlog1;

	assign idx_s1 = flow_hash_s1[IDX_W-1:0] & IDX_MASK;
	assign in_idx = flow_hash[IDX_W-1:0] & IDX_MASK;

	// A bucket committed by the item leaving stage 1 is not yet in the map
	// when the next item reads it on the same edge; forward it.
	assign spill_wr = adv_s1 && pick_s1.set_spill;
	assign fwd_hit  = spill_wr && (idx_s1 == in_idx);

	// Configuration writes; indexes past the register list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pick_mode_q  <= tpep_pkg::PICK_MODE_RESET;
			high_water_q <= tpep_pkg::HIGH_WATER_RESET;
			load_bias_q  <= tpep_pkg::LOAD_BIAS_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				tpep_pkg::REG_PICK_MODE:  pick_mode_q  <= cfg_data[tpep_pkg::MODE_W-1:0];
				tpep_pkg::REG_HIGH_WATER: high_water_q <= cfg_data;
				tpep_pkg::REG_LOAD_BIAS:  load_bias_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clearing pass: walk every bucket once after reset, one per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			if (clr_idx_q == LAST_BUCKET) begin
				clearing_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	// Spill map write port: zero fill during the clearing pass, then commit
	// buckets as items leave stage 1
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			spill_mem[clr_idx_q] <= 1'b0;
		end else if (spill_wr) begin
			spill_mem[idx_s1] <= 1'b1;
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload: load on every accepted item, bucket bit read with it
	always_ff @(posedge clk) begin
		if (in_accept) begin
			flow_hash_s1     <= flow_hash;
			port0_present_s1 <= port0_present;
			port1_present_s1 <= port1_present;
			backlog0_s1      <= sat0;
			backlog1_s1      <= sat1;
			pref_known_s1    <= pref_known;
			pref_port_s1     <= pref_port;
			bucket_hit_s1    <= spill_mem[in_idx] | fwd_hit;
		end
	end

	tpep_decide u_decide (
		.flow_hash      (flow_hash_s1),
		.port0_present  (port0_present_s1),
		.port1_present  (port1_present_s1),
		.backlog0       (backlog0_s1),
		.backlog1       (backlog1_s1),
		.pref_known     (pref_known_s1),
		.pref_port      (pref_port_s1),
		.pick_mode      (pick_mode_q),
		.high_water     (high_water_q),
		.load_bias      (load_bias_q),
		.bucket_spilled (bucket_hit_s1),
		.rr_phase       (rr_phase_q),
		.pick           (pick_s1)
	);

	// State updates commit only when the item leaves stage 1, so the next
	// item, arriving in stage 1 on the same edge, already sees them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rr_phase_q <= 1'b0;
		end else if (adv_s1 && pick_s1.rr_toggle) begin
			rr_phase_q <= ~rr_phase_q;
		end
	end

	// Stage 2 control: fill from stage 1, drain when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	// Stage 2 payload: hold while stalled
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			chosen_port_s2 <= pick_s1.chosen_port;
			port_valid_s2  <= pick_s1.port_valid;
			spilled_s2     <= pick_s1.spilled;
		end
	end

	assign out_valid   = valid_s2;
	assign chosen_port = chosen_port_s2;
	assign port_valid  = port_valid_s2;
	assign spilled     = spilled_s2;

endmodule
`default_nettype wire

/* sv/tpep_decide.sv */
`default_nettype none
module tpep_decide (
	input  wire logic [tpep_pkg::HASH_W-1:0]    flow_hash,
	input  wire logic                           port0_present,
	input  wire logic                           port1_present,
	input  wire logic [tpep_pkg::BACKLOG_W-1:0] backlog0,
	input  wire logic [tpep_pkg::BACKLOG_W-1:0] backlog1,
	input  wire logic                           pref_known,
	input  wire logic                           pref_port,
	input  wire logic [tpep_pkg::MODE_W-1:0]    pick_mode,
	input  wire logic [tpep_pkg::BACKLOG_W-1:0] high_water,
	input  wire logic [tpep_pkg::BACKLOG_W-1:0] load_bias,
	input  wire logic                           bucket_spilled,
	input  wire logic                           rr_phase,
	output tpep_pkg::pick_t                     pick
);

	logic                           pref_eff;
	logic [tpep_pkg::BACKLOG_W-1:0] b_pref;
	logic [tpep_pkg::BACKLOG_W-1:0] b_alt;
	logic                           over_high;
	logic                           alt_light;
	logic [tpep_pkg::BACKLOG_W:0]   sum0;
	logic [tpep_pkg::BACKLOG_W:0]   sum1;
	logic                           lean0;
	logic                           lean1;

	// Per-flow comparisons
	assign pref_eff  = pref_known ? pref_port : flow_hash[0];
	assign b_pref    = pref_eff ? backlog1 : backlog0;
	assign b_alt     = pref_eff ? backlog0 : backlog1;
	assign over_high = b_pref > high_water;
	assign alt_light = {b_alt, 1'b0} < {1'b0, b_pref};

	// Per-packet comparisons
	assign sum0  = {1'b0, backlog0} + {1'b0, load_bias};
	assign sum1  = {1'b0, backlog1} + {1'b0, load_bias};
	assign lean0 = sum0 < {1'b0, backlog1};
	assign lean1 = sum1 < {1'b0, backlog0};

	always_comb begin
		pick = '0;
		if (!port0_present && !port1_present) begin
			pick.port_valid = 1'b0;
		end else if (!port1_present) begin
			pick.port_valid = 1'b1;
		end else if (!port0_present) begin
			pick.port_valid  = 1'b1;
			pick.chosen_port = 1'b1;
		end else begin
			pick.port_valid = 1'b1;
			case (pick_mode)
				tpep_pkg::MODE_PACKET: begin
					if (lean0) begin
						pick.chosen_port = 1'b0;
					end else if (lean1) begin
						pick.chosen_port = 1'b1;
					end else begin
						pick.rr_toggle   = 1'b1;
						pick.chosen_port = ~rr_phase;
					end
					pick.spilled = pick.chosen_port;
				end
				tpep_pkg::MODE_ECMP: begin
					pick.chosen_port = flow_hash[0];
					pick.spilled     = flow_hash[0];
				end
				default: begin
					if (bucket_spilled) begin
						pick.chosen_port = ~pref_eff;
					end else if (over_high && alt_light) begin
						pick.chosen_port = ~pref_eff;
						pick.set_spill   = 1'b1;
						pick.spilled     = 1'b1;
					end else begin
						pick.chosen_port = pref_eff;
					end
				end
			endcase
		end
	end

endmodule
`default_nettype wire
